/* hw/rtl/slidm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// slidm_pkg: shared types and constants of the segmented log id manager
// Command and status codes, table sizes and the segment entry layout.
// ----------------------------------------------------------------------------
package slidm_pkg;

  localparam int MaxSegments = 8;
  localparam int MaxRecords  = 1024;
  localparam int SegW        = 3;
  localparam int CntW        = 11;
  localparam int IdW         = 64;
  localparam int EntryW      = IdW + CntW;

  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_LOOKUP  = 3'd1;
  localparam logic [2:0] CMD_NEXT    = 3'd2;
  localparam logic [2:0] CMD_PREV    = 3'd3;
  localparam logic [2:0] CMD_RELEASE = 3'd4;
  localparam logic [2:0] CMD_PAUSE   = 3'd5;
  localparam logic [2:0] CMD_RESUME  = 3'd6;
  localparam logic [2:0] CMD_CLEAR   = 3'd7;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_PAUSED    = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  localparam logic [0:0] REG_RPS  = 1'b0;
  localparam logic [0:0] REG_SEGS = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]  first_id;
    logic [CntW-1:0] count;
  } entry_t;

endpackage
`default_nettype wire

/* hw/rtl/slidm_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// slidm_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module slidm_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/segmented_log_id_manager_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// segmented_log_id_manager_top: segment table and record id allocator
// Work per item, for n active segments: pause, resume and a paused command
// go straight to the result; lookup and release take one sweep of the n
// entries, next/previous two, an append into the newest segment one, and an
// append that rotates three; clear waits for the clearing pass. One item at a
// time: the next item can be taken the cycle after the result is accepted.
// Sweeps read one table entry per cycle. After reset, a register write or
// clear, a clearing pass zeroes every table entry; no item is taken during it.
// ----------------------------------------------------------------------------
module segmented_log_id_manager_top
  import slidm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [71:0]  s_axis_tdata,  // command[2:0], record_id[66:3], zeros
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [151:0]      m_axis_tdata,  // status, result_id, segment_index,
                                           // slot, rotated, released_through
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [10:0]  cfg_data
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_ROT   = 4'd4;
  localparam logic [3:0] S_PICK  = 4'd5;
  localparam logic [3:0] S_LOC   = 4'd6;
  localparam logic [3:0] S_WRITE = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]      state;
  logic [CntW-1:0] rps_reg;
  logic [3:0]      segs_reg;
  logic [IdW-1:0]  released_id, next_first_id;
  logic            paused;
  logic            clr_reply;

  logic [2:0]      cmd;
  logic [IdW-1:0]  arg;
  logic [SegW:0]   idx;     // issue counter
  logic [SegW:0]   ridx;    // index of data on rdata
  logic            rvalid;

  logic [IdW-1:0]  latest, best, target_first, active_first;
  logic [SegW-1:0] target, active;
  logic            have_target, have_active, have_best, found;
  logic [CntW-1:0] active_cnt;
  logic [SegW-1:0] fseg;
  logic [CntW-1:0] fslot;
  logic [2:0]      status;
  logic [IdW-1:0]  rid;
  logic            rot;

  logic            we;
  logic [SegW-1:0] waddr, raddr;
  entry_t          wdata, rdata;

  // Effective register values.
  logic [CntW-1:0] rps;
  logic [3:0]      nsegs;
  assign rps   = (rps_reg == '0) ? CntW'(1) :
                 (rps_reg > CntW'(MaxRecords)) ? CntW'(MaxRecords) : rps_reg;
  assign nsegs = (segs_reg < 4'd2) ? 4'd2 :
                 (segs_reg > 4'(MaxSegments)) ? 4'(MaxSegments) : segs_reg;

  slidm_ram #(.Width(EntryW), .Depth(MaxSegments)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Per-entry derived values of the entry on the read port.
  logic [IdW-1:0] e_last, e_off;
  logic           e_used, e_cnt, e_holds;
  assign e_used  = rdata.first_id != '0;
  assign e_cnt   = rdata.count != '0;
  assign e_last  = rdata.first_id + IdW'(rdata.count) - IdW'(1);
  assign e_off   = arg - rdata.first_id;
  assign e_holds = e_used && arg >= rdata.first_id && e_off < IdW'(rdata.count);

  logic issuing, last_issue;
  assign issuing    = (state == S_SCAN || state == S_ROT || state == S_PICK ||
                       state == S_LOC) && idx < nsegs;
  assign last_issue = rvalid && ridx == nsegs - 4'd1;
  assign raddr      = idx[SegW-1:0];
  assign s_axis_tready = state == S_IDLE && !m_axis_tvalid && !cfg_we;

  // Rotation target test for the entry on the read port. An unused entry wins
  // at once; otherwise a fully released entry that is not the newest one is
  // taken when its first id is the lowest seen so far.
  logic pick_take;
  assign pick_take = !found &&
                     (!e_used ||
                      (!(e_cnt && (e_last > released_id || e_last == latest)) &&
                       (!have_target || rdata.first_id < target_first)));

  // Next/previous candidate from the entry on the read port.
  logic [IdW-1:0] cand;
  logic           cand_ok;
  always_comb begin
    cand = '0;
    cand_ok = 1'b0;
    if (cmd == CMD_NEXT) begin
      cand_ok = e_cnt && arg < e_last;
      cand = (arg < rdata.first_id) ? rdata.first_id : arg + IdW'(1);
      cand_ok = cand_ok && (!have_best || cand < best);
    end else begin
      cand_ok = e_cnt && arg > rdata.first_id;
      cand = (arg <= e_last) ? arg - IdW'(1) : e_last;
      cand_ok = cand_ok && cand > best;
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      rps_reg <= CntW'(64);
      segs_reg <= 4'd8;
      paused <= 1'b0;
      clr_reply <= 1'b0;
      released_id <= '0;
      next_first_id <= IdW'(1);
      idx <= '0;
      rvalid <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rvalid <= issuing;
      ridx <= idx;
      if (issuing) idx <= idx + 4'd1;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RPS:  rps_reg  <= cfg_data;
          REG_SEGS: segs_reg <= cfg_data[3:0];
          default: ;
        endcase
        released_id <= '0;
        next_first_id <= IdW'(1);
        clr_reply <= 1'b0;
        idx <= '0;
        state <= S_CLR;
      end else begin
        unique case (state)
          // Clearing pass; a clear command gets its result after it.
          S_CLR: begin
            idx <= idx + 4'd1;
            if (idx == 4'(MaxSegments - 1)) begin
              clr_reply <= 1'b0;
              state <= clr_reply ? S_OUT : S_IDLE;
            end
          end
          S_IDLE: begin
            if (s_axis_tvalid && s_axis_tready) begin
              cmd <= s_axis_tdata[2:0];
              arg <= s_axis_tdata[66:3];
              status <= ST_OK; rid <= '0; rot <= 1'b0; fseg <= '0; fslot <= '0;
              latest <= (s_axis_tdata[2:0] == CMD_RELEASE) ? released_id : '0;
              best <= '0; have_best <= 1'b0;
              have_active <= 1'b0; have_target <= 1'b0; found <= 1'b0;
              idx <= '0;
              if (paused && s_axis_tdata[2:0] != CMD_PAUSE &&
                  s_axis_tdata[2:0] != CMD_RESUME) begin
                status <= ST_PAUSED; state <= S_OUT;
              end else if (s_axis_tdata[2:0] == CMD_PAUSE) begin
                paused <= 1'b1; state <= S_OUT;
              end else if (s_axis_tdata[2:0] == CMD_RESUME) begin
                paused <= 1'b0; state <= S_OUT;
              end else if (s_axis_tdata[2:0] == CMD_CLEAR) begin
                released_id <= '0; next_first_id <= IdW'(1); state <= S_CLR;
                clr_reply <= 1'b1;
              end else if (s_axis_tdata[2:0] == CMD_LOOKUP) begin
                if (s_axis_tdata[66:3] == '0) begin
                  status <= ST_INVALID; state <= S_OUT;
                end else state <= S_LOC;
              end else begin
                state <= S_SCAN;
              end
            end
          end
          // Sweep: newest segment, latest id, or next/previous candidate.
          S_SCAN: begin
            if (rvalid) begin
              if (cmd == CMD_APPEND) begin
                if (e_used && (!have_active || rdata.first_id > active_first)) begin
                  have_active <= 1'b1; active <= ridx[SegW-1:0];
                  active_first <= rdata.first_id; active_cnt <= rdata.count;
                end
              end else if (cmd == CMD_RELEASE) begin
                if (e_cnt && e_last > latest) latest <= e_last;
              end else if (cand_ok) begin
                best <= cand; have_best <= 1'b1;
              end
              if (last_issue) state <= S_DEC;
            end
          end
          S_DEC: begin
            idx <= '0;
            if (cmd == CMD_APPEND) begin
              if (!have_active || active_cnt >= rps) begin
                latest <= '0; state <= S_ROT;
              end else state <= S_WRITE;
            end else if (cmd == CMD_RELEASE) begin
              if (arg > latest) status <= ST_INVALID;
              else if (arg > released_id) released_id <= arg;
              state <= S_OUT;
            end else if (best == '0) begin
              status <= ST_NOT_FOUND; state <= S_OUT;
            end else begin
              arg <= best; state <= S_LOC;
            end
          end
          // Rotation pass one: latest id over all segments.
          S_ROT: begin
            if (rvalid) begin
              if (e_cnt && e_last > latest) latest <= e_last;
              if (last_issue) begin idx <= '0; state <= S_PICK; end
            end
          end
          // Rotation pass two: choose the target entry.
          S_PICK: begin
            if (rvalid) begin
              if (pick_take) begin
                have_target <= 1'b1; target <= ridx[SegW-1:0];
                target_first <= rdata.first_id;
                if (!e_used) found <= 1'b1;
              end
              if (last_issue) begin
                if (!have_target && !pick_take) begin
                  status <= ST_FULL; state <= S_OUT;
                end else if (next_first_id > ~IdW'(0) - IdW'(rps)) begin
                  status <= ST_EXHAUSTED; state <= S_OUT;
                end else begin
                  rot <= 1'b1; state <= S_WRITE;
                end
              end
            end
          end
          // Locate sweep for lookup and next/previous.
          S_LOC: begin
            if (rvalid) begin
              if (e_holds && !found) begin
                found <= 1'b1; fseg <= ridx[SegW-1:0]; fslot <= e_off[CntW-1:0];
              end
              if (last_issue) state <= S_WRITE;
            end
          end
          S_WRITE: begin
            if (cmd == CMD_APPEND) begin
              if (rot) begin
                fseg <= target; fslot <= '0; rid <= next_first_id;
                next_first_id <= next_first_id + IdW'(rps);
              end else begin
                fseg <= active; fslot <= active_cnt; rid <= active_first + IdW'(active_cnt);
              end
            end else if (found) rid <= arg;
            else begin status <= ST_NOT_FOUND; fseg <= '0; fslot <= '0; end
            state <= S_OUT;
          end
          S_OUT: begin
            if (!m_axis_tvalid) begin
              m_axis_tvalid <= 1'b1;
              state <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // Table write port: clearing pass or append update.
  always_comb begin
    we = 1'b0; waddr = idx[SegW-1:0]; wdata = '0;
    if (state == S_CLR && !cfg_we) we = 1'b1;
    else if (state == S_WRITE && cmd == CMD_APPEND && !cfg_we) begin
      we = 1'b1;
      if (rot) begin
        waddr = target; wdata.first_id = next_first_id; wdata.count = CntW'(1);
      end else begin
        waddr = active; wdata.first_id = active_first; wdata.count = active_cnt + CntW'(1);
      end
    end
  end

  // Result packing.
  logic [SegW-1:0] out_seg;
  logic [9:0]      out_slot;
  assign out_seg  = fseg;
  assign out_slot = fslot[9:0];
  always_ff @(posedge clk) begin
    if (state == S_OUT && !m_axis_tvalid) begin
      m_axis_tdata <= {7'd0, released_id, rot, out_slot, out_seg, rid, status};
    end
  end

  // Assertions.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == S_IDLE) else $error("accept outside idle");
  a_out_after_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> state == S_IDLE) else $error("result without return");
  a_clr_no_out: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> !s_axis_tready) else $error("accept during clear");

endmodule
`default_nettype wire
